[rtl/hvd_pkg.sv]
package hvd_pkg;

  localparam int ITERATIONS_DEF = 24;

  localparam int LAT_W   = 31;
  localparam int LON_W   = 32;
  localparam int DIST_W  = 32;
  localparam int CFG_W   = 16;
  localparam int ADDR_W  = 3;
  localparam int DATA_W  = 32;

  localparam int TURN_W  = 33;
  localparam int CW      = 34;
  localparam int Q_W     = 32;
  localparam int ROOT_W  = 31;
  localparam int RAD_W   = 62;
  localparam int THETA_W = 31;
  localparam int ANGLE_W = 35;
  localparam int PIC_W   = 28;

  localparam int NUM_ANGLES = 4;
  localparam int SQRT_STEPS = 31;

  localparam int LANE_DLAT = 0;
  localparam int LANE_DLON = 1;
  localparam int LANE_LAT1 = 2;
  localparam int LANE_LAT2 = 3;

  localparam logic REG_RADIUS    = 1'b0;
  localparam logic REG_THRESHOLD = 1'b1;

  localparam logic [CFG_W-1:0] RADIUS_RESET    = 16'd6371;
  localparam logic [CFG_W-1:0] THRESHOLD_RESET = 16'd100;

  typedef logic signed [TURN_W-1:0] turn_t;
  typedef logic signed [CW-1:0]     cord_t;
  typedef logic signed [Q_W-1:0]    q_t;
  typedef logic [ROOT_W-1:0]        root_t;
  typedef logic [RAD_W-1:0]         rad_t;

  localparam cord_t CORDIC_GAIN = 34'sd652032874;
  localparam logic signed [35:0] DEG_90  = 36'sd1509949440;
  localparam logic signed [35:0] DEG_180 = 36'sd3019898880;
  localparam logic signed [35:0] DEG_360 = 36'sd6039797760;
  localparam cord_t Q30_ONE = 34'sd1073741824;
  localparam root_t Q30_ONE_U = 31'd1073741824;
  localparam logic [PIC_W-1:0] PI_OVER_90 = 28'd149922641;

  function automatic cord_t atan_deg(input int idx);
    cord_t r;
    case (idx)
      0:  r = 34'sd754974720;
      1:  r = 34'sd445687602;
      2:  r = 34'sd235489088;
      3:  r = 34'sd119537938;
      4:  r = 34'sd60000934;
      5:  r = 34'sd30029717;
      6:  r = 34'sd15018523;
      7:  r = 34'sd7509720;
      8:  r = 34'sd3754917;
      9:  r = 34'sd1877466;
      10: r = 34'sd938734;
      11: r = 34'sd469368;
      12: r = 34'sd234684;
      13: r = 34'sd117342;
      14: r = 34'sd58671;
      15: r = 34'sd29335;
      16: r = 34'sd14668;
      17: r = 34'sd7334;
      18: r = 34'sd3667;
      19: r = 34'sd1833;
      20: r = 34'sd917;
      21: r = 34'sd458;
      22: r = 34'sd229;
      23: r = 34'sd115;
      24: r = 34'sd57;
      25: r = 34'sd29;
      26: r = 34'sd14;
      27: r = 34'sd7;
      28: r = 34'sd4;
      29: r = 34'sd2;
      30: r = 34'sd1;
      default: r = 34'sd0;
    endcase
    return r;
  endfunction

endpackage

[rtl/hvd_query_if.sv]
interface hvd_query_if;
  logic                               valid;
  logic                               ready;
  logic signed [hvd_pkg::LAT_W-1:0]   first_latitude;
  logic signed [hvd_pkg::LON_W-1:0]   first_longitude;
  logic signed [hvd_pkg::LAT_W-1:0]   second_latitude;
  logic signed [hvd_pkg::LON_W-1:0]   second_longitude;

  modport source (
    output valid, first_latitude, first_longitude, second_latitude, second_longitude,
    input  ready
  );
  modport sink (
    input  valid, first_latitude, first_longitude, second_latitude, second_longitude,
    output ready
  );
endinterface

[rtl/hvd_result_if.sv]
interface hvd_result_if;
  logic                        valid;
  logic                        ready;
  logic [hvd_pkg::DIST_W-1:0]  distance;
  logic                        beyond_threshold;

  modport source (
    output valid, distance, beyond_threshold,
    input  ready
  );
  modport sink (
    input  valid, distance, beyond_threshold,
    output ready
  );
endinterface

[rtl/hvd_sincos.sv]
module hvd_sincos #(
  parameter int ITERATIONS = hvd_pkg::ITERATIONS_DEF
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           en,
  input  logic           in_valid,
  input  hvd_pkg::turn_t angle   [hvd_pkg::NUM_ANGLES],
  output logic           out_valid,
  output hvd_pkg::cord_t cos_raw [hvd_pkg::NUM_ANGLES],
  output hvd_pkg::cord_t sin_raw [hvd_pkg::NUM_ANGLES],
  output logic           neg_cos [hvd_pkg::NUM_ANGLES]
);
  import hvd_pkg::*;

  logic  valid [ITERATIONS+1];
  cord_t x     [ITERATIONS+1][NUM_ANGLES];
  cord_t y     [ITERATIONS+1][NUM_ANGLES];
  cord_t z     [ITERATIONS+1][NUM_ANGLES];
  logic  neg   [ITERATIONS+1][NUM_ANGLES];

  cord_t red_z   [NUM_ANGLES];
  logic  red_neg [NUM_ANGLES];

  // wrap into [-180, 180) then fold into [-90, 90]
  always_comb begin
    logic signed [35:0] v;
    logic signed [35:0] m;
    logic signed [35:0] f;
    for (int l = 0; l < NUM_ANGLES; l++) begin
      v = 36'(angle[l]);
      if (v < -DEG_180) begin
        m = v + DEG_360;
      end else if (v >= DEG_180) begin
        m = v - DEG_360;
      end else begin
        m = v;
      end
      red_neg[l] = 1'b0;
      f = m;
      if (m > DEG_90) begin
        f = DEG_180 - m;
        red_neg[l] = 1'b1;
      end else if (m < -DEG_90) begin
        f = -DEG_180 - m;
        red_neg[l] = 1'b1;
      end
      red_z[l] = f[CW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid[0] <= 1'b0;
    end else if (en) begin
      valid[0] <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int l = 0; l < NUM_ANGLES; l++) begin
        x[0][l]   <= CORDIC_GAIN;
        y[0][l]   <= '0;
        z[0][l]   <= red_z[l];
        neg[0][l] <= red_neg[l];
      end
    end
  end

  for (genvar i = 0; i < ITERATIONS; i++) begin : g_iter
    localparam cord_t ATAN_I = atan_deg(i);

    always_ff @(posedge clk) begin
      if (rst) begin
        valid[i+1] <= 1'b0;
      end else if (en) begin
        valid[i+1] <= valid[i];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        for (int l = 0; l < NUM_ANGLES; l++) begin
          neg[i+1][l] <= neg[i][l];
          if (!z[i][l][CW-1]) begin
            x[i+1][l] <= x[i][l] - (y[i][l] >>> i);
            y[i+1][l] <= y[i][l] + (x[i][l] >>> i);
            z[i+1][l] <= z[i][l] - ATAN_I;
          end else begin
            x[i+1][l] <= x[i][l] + (y[i][l] >>> i);
            y[i+1][l] <= y[i][l] - (x[i][l] >>> i);
            z[i+1][l] <= z[i][l] + ATAN_I;
          end
        end
      end
    end
  end

  assign out_valid = valid[ITERATIONS];
  always_comb begin
    for (int l = 0; l < NUM_ANGLES; l++) begin
      cos_raw[l] = x[ITERATIONS][l];
      sin_raw[l] = y[ITERATIONS][l];
      neg_cos[l] = neg[ITERATIONS][l];
    end
  end

endmodule

[rtl/hvd_sqrt.sv]
module hvd_sqrt (
  input  logic           clk,
  input  logic           rst,
  input  logic           en,
  input  logic           in_valid,
  input  hvd_pkg::root_t a,
  output logic           out_valid,
  output hvd_pkg::root_t root_a,
  output hvd_pkg::root_t root_b
);
  import hvd_pkg::*;

  // lane 0 takes sqrt(a), lane 1 takes sqrt(1 - a), both on Q60 radicands
  logic valid [SQRT_STEPS];
  rad_t rem   [SQRT_STEPS][2];
  rad_t root  [SQRT_STEPS][2];

  rad_t rad [2];
  assign rad[0] = {1'b0, a, 30'd0};
  assign rad[1] = {1'b0, Q30_ONE_U - a, 30'd0};

  for (genvar s = 0; s < SQRT_STEPS; s++) begin : g_step
    localparam int   K   = SQRT_STEPS - 1 - s;
    localparam rad_t BIT = rad_t'(1) << (2 * K);
    logic src_valid;
    rad_t src_rem  [2];
    rad_t src_root [2];

    if (s == 0) begin : g_first
      assign src_valid   = in_valid;
      assign src_rem[0]  = rad[0];
      assign src_rem[1]  = rad[1];
      assign src_root[0] = '0;
      assign src_root[1] = '0;
    end else begin : g_next
      assign src_valid   = valid[s-1];
      assign src_rem[0]  = rem[s-1][0];
      assign src_rem[1]  = rem[s-1][1];
      assign src_root[0] = root[s-1][0];
      assign src_root[1] = root[s-1][1];
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        valid[s] <= 1'b0;
      end else if (en) begin
        valid[s] <= src_valid;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        for (int l = 0; l < 2; l++) begin
          if (src_rem[l] >= src_root[l] + BIT) begin
            rem[s][l]  <= src_rem[l] - (src_root[l] + BIT);
            root[s][l] <= (src_root[l] >> 1) + BIT;
          end else begin
            rem[s][l]  <= src_rem[l];
            root[s][l] <= src_root[l] >> 1;
          end
        end
      end
    end
  end

  assign out_valid = valid[SQRT_STEPS-1];
  assign root_a    = root[SQRT_STEPS-1][0][ROOT_W-1:0];
  assign root_b    = root[SQRT_STEPS-1][1][ROOT_W-1:0];

endmodule

[rtl/hvd_atan.sv]
module hvd_atan #(
  parameter int ITERATIONS = hvd_pkg::ITERATIONS_DEF
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           en,
  input  logic           in_valid,
  input  hvd_pkg::root_t root_a,
  input  hvd_pkg::root_t root_b,
  output logic           out_valid,
  output hvd_pkg::cord_t theta
);
  import hvd_pkg::*;

  logic  valid [ITERATIONS];
  cord_t x     [ITERATIONS];
  cord_t y     [ITERATIONS];
  cord_t z     [ITERATIONS];

  for (genvar i = 0; i < ITERATIONS; i++) begin : g_iter
    localparam cord_t ATAN_I = atan_deg(i);
    logic  src_valid;
    cord_t sx;
    cord_t sy;
    cord_t sz;

    if (i == 0) begin : g_first
      assign src_valid = in_valid;
      assign sx        = {3'b000, root_b};
      assign sy        = {3'b000, root_a};
      assign sz        = '0;
    end else begin : g_next
      assign src_valid = valid[i-1];
      assign sx        = x[i-1];
      assign sy        = y[i-1];
      assign sz        = z[i-1];
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        valid[i] <= 1'b0;
      end else if (en) begin
        valid[i] <= src_valid;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        if (!sy[CW-1]) begin
          x[i] <= sx + (sy >>> i);
          y[i] <= sy - (sx >>> i);
          z[i] <= sz + ATAN_I;
        end else begin
          x[i] <= sx - (sy >>> i);
          y[i] <= sy + (sx >>> i);
          z[i] <= sz - ATAN_I;
        end
      end
    end
  end

  assign out_valid = valid[ITERATIONS-1];
  assign theta     = z[ITERATIONS-1];

endmodule

[rtl/haversine_distance_unit.sv]
// throughput: one beat per cycle; the cordic stages, the 31 square root steps and the
// multiplier stages each hold one item, and query stalls only while the output skid is full
// reset: synchronous, clears every valid bit and the skid, radius to 6371 km and
// threshold to 100 km
module haversine_distance_unit #(
  parameter int ITERATIONS = hvd_pkg::ITERATIONS_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  hvd_query_if.sink                   query,
  hvd_result_if.source                result,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [hvd_pkg::ADDR_W-1:0]  paddr,
  input  logic [hvd_pkg::DATA_W-1:0]  pwdata,
  output logic [hvd_pkg::DATA_W-1:0]  prdata,
  output logic                        pready
);
  import hvd_pkg::*;

  function automatic q_t clamp_unit(input cord_t v);
    cord_t r;
    if (v > Q30_ONE) begin
      r = Q30_ONE;
    end else if (v < -Q30_ONE) begin
      r = -Q30_ONE;
    end else begin
      r = v;
    end
    return r[Q_W-1:0];
  endfunction

  logic [CFG_W-1:0] radius;
  logic [CFG_W-1:0] threshold;

  // config port
  assign pready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      radius    <= RADIUS_RESET;
      threshold <= THRESHOLD_RESET;
    end else if (psel && penable && pwrite) begin
      case (paddr[2])
        REG_RADIUS:    radius    <= pwdata[CFG_W-1:0];
        REG_THRESHOLD: threshold <= pwdata[CFG_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      REG_RADIUS:    prdata = {{(DATA_W-CFG_W){1'b0}}, radius};
      REG_THRESHOLD: prdata = {{(DATA_W-CFG_W){1'b0}}, threshold};
      default:       prdata = '0;
    endcase
  end

  logic en;
  logic skid_valid;
  assign en          = !skid_valid;
  assign query.ready = en;

  // angle stage
  logic  va;
  turn_t ang [NUM_ANGLES];

  always_ff @(posedge clk) begin
    if (rst) begin
      va <= 1'b0;
    end else if (en) begin
      va <= query.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ang[LANE_DLAT] <= turn_t'(query.second_latitude) - turn_t'(query.first_latitude);
      ang[LANE_DLON] <= turn_t'(query.second_longitude) - turn_t'(query.first_longitude);
      ang[LANE_LAT1] <= turn_t'(query.first_latitude) <<< 1;
      ang[LANE_LAT2] <= turn_t'(query.second_latitude) <<< 1;
    end
  end

  logic  vsc;
  cord_t cos_raw [NUM_ANGLES];
  cord_t sin_raw [NUM_ANGLES];
  logic  neg_cos [NUM_ANGLES];

  hvd_sincos #(.ITERATIONS(ITERATIONS)) u_sincos (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (va),
    .angle     (ang),
    .out_valid (vsc),
    .cos_raw   (cos_raw),
    .sin_raw   (sin_raw),
    .neg_cos   (neg_cos)
  );

  // squares and cosine product
  q_t s_lat;
  q_t s_lon;
  q_t c1;
  q_t c2;
  logic signed [63:0] p_lat;
  logic signed [63:0] p_lon;
  logic signed [63:0] p_cc;

  always_comb begin
    s_lat = clamp_unit(sin_raw[LANE_DLAT]);
    s_lon = clamp_unit(sin_raw[LANE_DLON]);
    c1    = clamp_unit(neg_cos[LANE_LAT1] ? -cos_raw[LANE_LAT1] : cos_raw[LANE_LAT1]);
    c2    = clamp_unit(neg_cos[LANE_LAT2] ? -cos_raw[LANE_LAT2] : cos_raw[LANE_LAT2]);
    p_lat = 64'(s_lat) * 64'(s_lat);
    p_lon = 64'(s_lon) * 64'(s_lon);
    p_cc  = 64'(c1) * 64'(c2);
  end

  logic vp1;
  q_t   sq_lat;
  q_t   sq_lon;
  q_t   cc;

  always_ff @(posedge clk) begin
    if (rst) begin
      vp1 <= 1'b0;
    end else if (en) begin
      vp1 <= vsc;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sq_lat <= q_t'(p_lat >>> 30);
      sq_lon <= q_t'(p_lon >>> 30);
      cc     <= q_t'(p_cc >>> 30);
    end
  end

  // haversine term
  logic signed [63:0] p_term;
  logic signed [32:0] a_sum;
  root_t              a_next;

  always_comb begin
    p_term = 64'(sq_lon) * 64'(cc);
    a_sum  = 33'(sq_lat) + 33'(q_t'(p_term >>> 30));
    if (a_sum < 0) begin
      a_next = '0;
    end else if (a_sum > 33'sd1073741824) begin
      a_next = Q30_ONE_U;
    end else begin
      a_next = a_sum[ROOT_W-1:0];
    end
  end

  logic  vp2;
  root_t a_q;

  always_ff @(posedge clk) begin
    if (rst) begin
      vp2 <= 1'b0;
    end else if (en) begin
      vp2 <= vp1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a_q <= a_next;
    end
  end

  logic  vsq;
  root_t root_a;
  root_t root_b;

  hvd_sqrt u_sqrt (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (vp2),
    .a         (a_q),
    .out_valid (vsq),
    .root_a    (root_a),
    .root_b    (root_b)
  );

  logic  vat;
  cord_t theta;

  hvd_atan #(.ITERATIONS(ITERATIONS)) u_atan (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (vsq),
    .root_a    (root_a),
    .root_b    (root_b),
    .out_valid (vat),
    .theta     (theta)
  );

  // degrees to radians, times two for the central angle
  logic [THETA_W-1:0] theta_pos;
  logic [58:0]        p_angle;

  assign theta_pos = theta[CW-1] ? '0 : theta[THETA_W-1:0];
  assign p_angle   = 59'(theta_pos) * 59'(PI_OVER_90);

  logic               vs1;
  logic [ANGLE_W-1:0] angle;

  always_ff @(posedge clk) begin
    if (rst) begin
      vs1 <= 1'b0;
    end else if (en) begin
      vs1 <= vat;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      angle <= p_angle[58:24];
    end
  end

  // radius scaling
  logic [50:0] p_dist;
  assign p_dist = 51'(angle) * 51'(radius);

  logic               vs2;
  logic [ANGLE_W-1:0] dist_raw;

  always_ff @(posedge clk) begin
    if (rst) begin
      vs2 <= 1'b0;
    end else if (en) begin
      vs2 <= vs1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dist_raw <= p_dist[50:16];
    end
  end

  // saturation and threshold
  logic              vf;
  logic [DIST_W-1:0] dist_f;
  logic              beyond_f;

  always_ff @(posedge clk) begin
    if (rst) begin
      vf <= 1'b0;
    end else if (en) begin
      vf <= vs2;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dist_f   <= (|dist_raw[ANGLE_W-1:DIST_W]) ? '1 : dist_raw[DIST_W-1:0];
      beyond_f <= dist_raw > {3'b000, threshold, 16'd0};
    end
  end

  // output skid
  logic [DIST_W-1:0] skid_dist;
  logic              skid_beyond;

  always_ff @(posedge clk) begin
    if (rst) begin
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      if (result.ready) begin
        skid_valid <= 1'b0;
      end
    end else if (vf && !result.ready) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!skid_valid) begin
      skid_dist   <= dist_f;
      skid_beyond <= beyond_f;
    end
  end

  assign result.valid            = skid_valid || vf;
  assign result.distance         = skid_valid ? skid_dist : dist_f;
  assign result.beyond_threshold = skid_valid ? skid_beyond : beyond_f;

endmodule

[rtl/hvd_checker.sv]
module hvd_checker (
  input logic                        clk,
  input logic                        rst,
  input logic                        query_valid,
  input logic                        query_ready,
  input logic                        result_valid,
  input logic                        result_ready,
  input logic [hvd_pkg::DIST_W-1:0]  distance,
  input logic                        beyond_threshold
);

  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_ready |=> result_valid && $stable(distance)
      && $stable(beyond_threshold))
    else $error("result beat changed while stalled");

  a_reset_empty: assert property (@(posedge clk)
    $past(rst) && !rst |-> !result_valid)
    else $error("result beat right after reset");

  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    !query_ready |-> $past(result_valid && !result_ready))
    else $error("query stalled without a stalled result");

  a_zero_flag: assert property (@(posedge clk) disable iff (rst)
    result_valid && distance == '0 |-> !beyond_threshold)
    else $error("flag set on zero distance");

endmodule

bind haversine_distance_unit hvd_checker u_hvd_checker (
  .clk              (clk),
  .rst              (rst),
  .query_valid      (query.valid),
  .query_ready      (query.ready),
  .result_valid     (result.valid),
  .result_ready     (result.ready),
  .distance         (result.distance),
  .beyond_threshold (result.beyond_threshold)
);
